// ----- hdl/mspt_pkg.sv -----
// Shared constants for the periodic timer slot bank.
package mspt_pkg;

  // Request codes
  localparam logic [1:0] REQ_TICK = 2'd0;
  localparam logic [1:0] REQ_SET  = 2'd1;
  localparam logic [1:0] REQ_DEL  = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_FREE   = 2'd1;
  localparam logic [1:0] ST_ZERO_PER  = 2'd2;

  // Fixed port field widths
  localparam int unsigned REQ_W    = 2;
  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned UTAG_W   = 32;
  localparam int unsigned HANDLE_W = 4;
  localparam int unsigned STATUS_W = 2;

  // Most expiry items reported for one tick
  localparam int unsigned RESULT_LIMIT = 16;

  // Parameter defaults
  localparam int unsigned DEF_SLOT_COUNT  = 16;
  localparam int unsigned DEF_COUNT_WIDTH = 16;
  localparam int unsigned DEF_TAG_WIDTH   = 32;

endpackage

// ----- hdl/multi_slot_periodic_timer_bank.sv -----
// Periodic timer slot bank: sequencer, slot memory and output register.
//
// A set request searches the active bits one slot per cycle for the lowest
// free slot; delete and other requests go straight to the reply state. A
// tick walks the slots in order: an idle slot is only checked in the read
// state, and an active slot is read from slot memory, then compared and
// written back through the single shared incrementer/comparator; a closing
// state sends the final item. Expiries come out in slot order; the last item
// of a tick carries last, and a tick without an expiry gives one empty item.
// The slot memory has one read and one write port and needs no clearing
// pass after reset. in_ready_o is high only between requests; the output
// register lets the next request start while the previous reply waits to
// be taken.
module multi_slot_periodic_timer_bank #(
  parameter int unsigned SLOT_COUNT  = mspt_pkg::DEF_SLOT_COUNT,
  parameter int unsigned COUNT_WIDTH = mspt_pkg::DEF_COUNT_WIDTH,
  parameter int unsigned TAG_WIDTH   = mspt_pkg::DEF_TAG_WIDTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [mspt_pkg::REQ_W-1:0]      req_type_i,
  input  logic [mspt_pkg::PERIOD_W-1:0]   period_i,
  input  logic [mspt_pkg::UTAG_W-1:0]     user_tag_i,
  input  logic [mspt_pkg::HANDLE_W-1:0]   slot_handle_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [mspt_pkg::STATUS_W-1:0]   status_o,
  output logic [mspt_pkg::HANDLE_W-1:0]   granted_slot_o,
  output logic                            fired_o,
  output logic [mspt_pkg::HANDLE_W-1:0]   fired_slot_o,
  output logic [mspt_pkg::UTAG_W-1:0]     fired_tag_o,
  output logic                            last_o
);
  import mspt_pkg::*;

  localparam int unsigned IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned N_W   = $clog2(RESULT_LIMIT + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

  typedef struct packed {
    logic [COUNT_WIDTH-1:0] period;
    logic [COUNT_WIDTH-1:0] elapsed;
    logic [TAG_WIDTH-1:0]   tag;
  } entry_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SET_SCAN,
    S_TICK_RD,
    S_TICK_EV,
    S_TICK_END,
    S_REPLY
  } state_e;

  state_e                 state_q;
  logic [IDX_W-1:0]       idx_q;
  logic [SLOT_COUNT-1:0]  active_q;
  logic [COUNT_WIDTH-1:0] per_q;
  logic [TAG_WIDTH-1:0]   tag_q;
  logic [N_W-1:0]         n_q;
  logic                   pend_valid_q;
  logic [IDX_W-1:0]       pend_slot_q;
  logic [TAG_WIDTH-1:0]   pend_tag_q;
  logic [STATUS_W-1:0]    rep_status_q;
  logic [IDX_W-1:0]       rep_slot_q;

  logic                   out_valid_q;
  logic [STATUS_W-1:0]    status_q;
  logic [HANDLE_W-1:0]    granted_q;
  logic                   fired_q;
  logic [HANDLE_W-1:0]    fslot_q;
  logic [UTAG_W-1:0]      ftag_q;
  logic                   last_q;

  entry_t                 mem_q [SLOT_COUNT];
  entry_t                 rd_q;

  logic                   mem_we;
  entry_t                 mem_wdata;
  logic                   out_free;
  logic                   out_load;
  logic [COUNT_WIDTH-1:0] cnt_inc;
  logic                   hit;
  logic                   report;
  logic                   ev_stall;
  logic                   in_fire;
  logic [COUNT_WIDTH-1:0] in_per;
  logic [IDX_W-1:0]       del_idx;
  logic                   del_ok;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign in_per     = COUNT_WIDTH'(period_i);
  assign del_idx    = IDX_W'(slot_handle_i);
  assign del_ok     = (32'(slot_handle_i) < 32'(SLOT_COUNT));

  // Shared increment and compare for the slot under visit
  assign cnt_inc  = COUNT_WIDTH'(rd_q.elapsed + 1'b1);
  assign hit      = (cnt_inc == rd_q.period);
  assign report   = (n_q < N_W'(RESULT_LIMIT));
  // A new expiry must push the held one out first
  assign ev_stall = hit && report && pend_valid_q && !out_free;

  // Output register takes a new item this cycle
  assign out_load = ((state_q == S_TICK_EV) && !ev_stall && hit && report && pend_valid_q) ||
                    (((state_q == S_TICK_END) || (state_q == S_REPLY)) && out_free);

  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = rd_q;
    unique case (state_q)
      S_SET_SCAN: begin
        mem_we    = !active_q[idx_q];
        mem_wdata = '{period: per_q, elapsed: '0, tag: tag_q};
      end
      S_TICK_EV: begin
        mem_we            = !ev_stall;
        mem_wdata.elapsed = hit ? '0 : cnt_inc;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[idx_q] <= mem_wdata;
    end
    rd_q <= mem_q[idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      idx_q        <= '0;
      active_q     <= '0;
      per_q        <= '0;
      tag_q        <= '0;
      n_q          <= '0;
      pend_valid_q <= 1'b0;
      pend_slot_q  <= '0;
      pend_tag_q   <= '0;
      rep_status_q <= ST_OK;
      rep_slot_q   <= '0;
      out_valid_q  <= 1'b0;
      status_q     <= ST_OK;
      granted_q    <= '0;
      fired_q      <= 1'b0;
      fslot_q      <= '0;
      ftag_q       <= '0;
      last_q       <= 1'b0;
    end else begin
      if (out_ready_i && !out_load) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_fire) begin
            per_q        <= in_per;
            tag_q        <= TAG_WIDTH'(user_tag_i);
            idx_q        <= '0;
            n_q          <= '0;
            pend_valid_q <= 1'b0;
            rep_status_q <= ST_OK;
            rep_slot_q   <= '0;
            unique case (req_type_i)
              REQ_TICK: state_q <= S_TICK_RD;
              REQ_SET: begin
                if (in_per == '0) begin
                  rep_status_q <= ST_ZERO_PER;
                  state_q      <= S_REPLY;
                end else begin
                  state_q <= S_SET_SCAN;
                end
              end
              REQ_DEL: begin
                if (del_ok) begin
                  active_q[del_idx] <= 1'b0;
                end
                state_q <= S_REPLY;
              end
              default: state_q <= S_REPLY;
            endcase
          end
        end
        S_SET_SCAN: begin
          if (!active_q[idx_q]) begin
            active_q[idx_q] <= 1'b1;
            rep_slot_q      <= idx_q;
            state_q         <= S_REPLY;
          end else if (idx_q == LAST_IDX) begin
            rep_status_q <= ST_NO_FREE;
            state_q      <= S_REPLY;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        S_TICK_RD: begin
          if (active_q[idx_q]) begin
            state_q <= S_TICK_EV;
          end else if (idx_q == LAST_IDX) begin
            state_q <= S_TICK_END;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        S_TICK_EV: begin
          if (!ev_stall) begin
            if (hit && report) begin
              if (pend_valid_q) begin
                out_valid_q <= 1'b1;
                status_q    <= ST_OK;
                granted_q   <= '0;
                fired_q     <= 1'b1;
                fslot_q     <= HANDLE_W'(pend_slot_q);
                ftag_q      <= UTAG_W'(pend_tag_q);
                last_q      <= 1'b0;
              end
              pend_valid_q <= 1'b1;
              pend_slot_q  <= idx_q;
              pend_tag_q   <= rd_q.tag;
              n_q          <= n_q + 1'b1;
            end
            if (idx_q == LAST_IDX) begin
              state_q <= S_TICK_END;
            end else begin
              idx_q   <= idx_q + 1'b1;
              state_q <= S_TICK_RD;
            end
          end
        end
        S_TICK_END: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            status_q    <= ST_OK;
            granted_q   <= '0;
            fired_q     <= pend_valid_q;
            fslot_q     <= pend_valid_q ? HANDLE_W'(pend_slot_q) : '0;
            ftag_q      <= pend_valid_q ? UTAG_W'(pend_tag_q) : '0;
            last_q      <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        S_REPLY: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            status_q    <= rep_status_q;
            granted_q   <= HANDLE_W'(rep_slot_q);
            fired_q     <= 1'b0;
            fslot_q     <= '0;
            ftag_q      <= '0;
            last_q      <= 1'b1;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign granted_slot_o = granted_q;
  assign fired_o        = fired_q;
  assign fired_slot_o   = fslot_q;
  assign fired_tag_o    = ftag_q;
  assign last_o         = last_q;

endmodule
